// ===== rtl/mrrd_pkg.sv =====
package mrrd_pkg;

  localparam int unsigned MaxFrame = 512;
  localparam int unsigned LenW     = 10;
  localparam int unsigned CntW     = $clog2(MaxFrame + 1);
  localparam int unsigned ExpW     = 9;
  localparam int unsigned CmpW     = 11;
  localparam int unsigned TmoW     = 16;
  localparam int unsigned GapW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = TmoW;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindByte  = 2'd1;
  localparam logic [1:0] KindTick  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGap     = 1'b1;

  localparam logic [TmoW-1:0] TimeoutReset = 16'd1000;
  localparam logic [GapW-1:0] GapReset     = 7'd5;
  localparam logic [GapW-1:0] GapMin       = 7'd5;
  localparam logic [GapW-1:0] GapMax       = 7'd100;

  localparam logic [7:0] FcWriteMulti = 8'h10;
  localparam logic [7:0] FcReadHold   = 8'h03;
  localparam logic [7:0] FcReadInput  = 8'h04;

  localparam logic [ExpW-1:0] ExcLength   = 9'd5;
  localparam logic [ExpW-1:0] WrMulLength = 9'd8;
  localparam logic [ExpW-1:0] RdHdrLength = 9'd5;

  typedef enum logic [1:0] {
    CauseLength   = 2'd0,
    CauseSilence  = 2'd1,
    CauseNoResp   = 2'd2,
    CauseOverflow = 2'd3
  } cause_t;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic            byte_valid;
    logic            frame_end;
    cause_t          end_cause;
    logic [LenW-1:0] frame_length;
  } result_t;

  typedef struct packed {
    logic       take;
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } step_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } step_res_t;

endpackage

// ===== rtl/mrrd_in_if.sv =====
interface mrrd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== rtl/mrrd_out_if.sv =====
interface mrrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       frame_end;
  logic [1:0] end_cause;
  logic [9:0] frame_length;

  modport source (output valid, output byte_out, output byte_valid, output frame_end,
                  output end_cause, output frame_length, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input frame_end,
                  input end_cause, input frame_length, output ready);
endinterface

// ===== rtl/mrrd_core.sv =====
module mrrd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrrd_pkg::step_t               step,
  input  logic [mrrd_pkg::TmoW-1:0]     timeout_cfg,
  input  logic [mrrd_pkg::GapW-1:0]     gap_cfg,
  output mrrd_pkg::step_res_t           res
);

  logic                          waiting_r, waiting_nxt;
  logic [mrrd_pkg::CntW-1:0]     bytes_r, bytes_nxt;
  logic [7:0]                    fc_r, fc_nxt;
  logic [7:0]                    dc_r, dc_nxt;
  logic [mrrd_pkg::TmoW-1:0]     total_r, total_nxt;
  logic [mrrd_pkg::GapW-1:0]     silence_r, silence_nxt;

  logic [mrrd_pkg::CntW-1:0]     bytes_inc;
  logic [7:0]                    fc_byte, dc_byte;
  logic [mrrd_pkg::ExpW-1:0]     exp_cur, exp_byte;
  logic [mrrd_pkg::TmoW-1:0]     limit, total_inc;
  logic [mrrd_pkg::GapW-1:0]     gap, silence_inc;
  logic                          len_hit, ovf_hit, tmo_hit, sil_run, sil_hit;

  function automatic logic [mrrd_pkg::ExpW-1:0] expected_len(
    input logic [mrrd_pkg::CntW-1:0] seen,
    input logic [7:0]                fc,
    input logic [7:0]                dc
  );
    logic [mrrd_pkg::ExpW-1:0] len;
    len = '0;
    if (mrrd_pkg::CmpW'(seen) >= mrrd_pkg::CmpW'(2)) begin
      if (fc[7]) begin
        len = mrrd_pkg::ExcLength;
      end else if (fc == mrrd_pkg::FcWriteMulti) begin
        len = mrrd_pkg::WrMulLength;
      end else if ((fc == mrrd_pkg::FcReadHold || fc == mrrd_pkg::FcReadInput) &&
                   mrrd_pkg::CmpW'(seen) >= mrrd_pkg::CmpW'(3)) begin
        len = mrrd_pkg::ExpW'(dc) + mrrd_pkg::RdHdrLength;
      end
    end
    return len;
  endfunction

  always_comb begin
    bytes_inc = bytes_r + mrrd_pkg::CntW'(1);
    fc_byte   = (mrrd_pkg::CmpW'(bytes_r) == mrrd_pkg::CmpW'(1)) ? step.rx_byte : fc_r;
    dc_byte   = (mrrd_pkg::CmpW'(bytes_r) == mrrd_pkg::CmpW'(2)) ? step.rx_byte : dc_r;
    exp_cur   = expected_len(bytes_r, fc_r, dc_r);
    exp_byte  = expected_len(bytes_inc, fc_byte, dc_byte);
    len_hit   = (exp_byte != '0) &&
                (mrrd_pkg::CmpW'(bytes_inc) >= mrrd_pkg::CmpW'(exp_byte));
    ovf_hit   = mrrd_pkg::CmpW'(bytes_inc) >= mrrd_pkg::CmpW'(mrrd_pkg::MaxFrame);

    limit     = (timeout_cfg == '0) ? mrrd_pkg::TmoW'(1) : timeout_cfg;
    gap       = (gap_cfg < mrrd_pkg::GapMin) ? mrrd_pkg::GapMin :
                (gap_cfg > mrrd_pkg::GapMax) ? mrrd_pkg::GapMax : gap_cfg;
    total_inc = (total_r == '1) ? total_r : total_r + mrrd_pkg::TmoW'(1);
    tmo_hit   = total_inc >= limit;
    sil_run   = (bytes_r != '0) && (exp_cur == '0);
    silence_inc = (silence_r == '1) ? silence_r : silence_r + mrrd_pkg::GapW'(1);
    sil_hit   = sil_run && (silence_inc >= gap);
  end

  always_comb begin
    waiting_nxt = waiting_r;
    bytes_nxt   = bytes_r;
    fc_nxt      = fc_r;
    dc_nxt      = dc_r;
    total_nxt   = total_r;
    silence_nxt = silence_r;
    if (step.take) begin
      if (step.kind == mrrd_pkg::KindStart) begin
        waiting_nxt = 1'b1;
        bytes_nxt   = '0;
        fc_nxt      = '0;
        dc_nxt      = '0;
        total_nxt   = '0;
        silence_nxt = '0;
      end else if (waiting_r && step.kind == mrrd_pkg::KindByte) begin
        bytes_nxt   = bytes_inc;
        fc_nxt      = fc_byte;
        dc_nxt      = dc_byte;
        silence_nxt = '0;
        if (len_hit || ovf_hit) begin
          waiting_nxt = 1'b0;
        end
      end else if (waiting_r && step.kind == mrrd_pkg::KindTick) begin
        total_nxt = total_inc;
        if (sil_run) begin
          silence_nxt = silence_inc;
        end
        if (tmo_hit || sil_hit) begin
          waiting_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.valid                   = 1'b0;
    res.data.byte_out           = '0;
    res.data.byte_valid         = 1'b0;
    res.data.frame_end          = 1'b0;
    res.data.end_cause          = mrrd_pkg::CauseLength;
    res.data.frame_length       = mrrd_pkg::LenW'(bytes_nxt);
    if (step.take && waiting_r) begin
      if (step.kind == mrrd_pkg::KindByte) begin
        res.valid               = 1'b1;
        res.data.byte_out       = step.rx_byte;
        res.data.byte_valid     = 1'b1;
        res.data.frame_end      = len_hit || ovf_hit;
        res.data.end_cause      = len_hit ? mrrd_pkg::CauseLength :
                                  ovf_hit ? mrrd_pkg::CauseOverflow : mrrd_pkg::CauseLength;
      end else if (step.kind == mrrd_pkg::KindTick && (tmo_hit || sil_hit)) begin
        res.valid               = 1'b1;
        res.data.frame_end      = 1'b1;
        res.data.end_cause      = (bytes_r == '0) ? mrrd_pkg::CauseNoResp :
                                                    mrrd_pkg::CauseSilence;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      bytes_r   <= '0;
      fc_r      <= '0;
      dc_r      <= '0;
      total_r   <= '0;
      silence_r <= '0;
    end else begin
      waiting_r <= waiting_nxt;
      bytes_r   <= bytes_nxt;
      fc_r      <= fc_nxt;
      dc_r      <= dc_nxt;
      total_r   <= total_nxt;
      silence_r <= silence_nxt;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.take && step.kind == mrrd_pkg::KindStart |=> waiting_r && bytes_r == '0)
    else $error("start did not arm a clean frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mrrd_pkg::CmpW'(bytes_r) <= mrrd_pkg::CmpW'(mrrd_pkg::MaxFrame))
    else $error("byte count beyond frame limit");

  a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.data.frame_end |=> !waiting_r)
    else $error("frame end left the block armed");

  a_res_armed: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> step.take && waiting_r)
    else $error("result while idle");

endmodule

// ===== rtl/modbus_rtu_response_delimiter_unit.sv =====
// channel | dir | handshake     | payload
// in_ch   | in  | valid/ready   | kind[1:0], rx_byte[7:0]
// out_ch  | out | valid/ready   | byte_out, byte_valid, frame_end, end_cause, frame_length
// cfg     | in  | cfg_we        | cfg_idx (0 timeout, 1 gap), cfg_wdata[15:0]
//
// One item per cycle while in_ch.ready is high; its result is in the output register on the next cycle.
// The frame state updates in the accept cycle; the output register holds one result.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Synchronous active-low reset clears the frame state and the output valid.
// Reset loads timeout 1000 and gap 5.
module modbus_rtu_response_delimiter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  mrrd_in_if.sink                           in_ch,
  mrrd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mrrd_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [mrrd_pkg::CfgDataW-1:0]     cfg_wdata
);

  logic [mrrd_pkg::TmoW-1:0] timeout_r;
  logic [mrrd_pkg::GapW-1:0] gap_r;
  logic                      out_valid_r, out_valid_nxt;
  mrrd_pkg::result_t         out_data_r;
  mrrd_pkg::step_t           step;
  mrrd_pkg::step_res_t       res;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign step.take    = in_ch.valid && in_ch.ready;
  assign step.kind    = in_ch.kind;
  assign step.rx_byte = in_ch.rx_byte;

  mrrd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .timeout_cfg (timeout_r),
    .gap_cfg     (gap_r),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      timeout_r   <= mrrd_pkg::TimeoutReset;
      gap_r       <= mrrd_pkg::GapReset;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == mrrd_pkg::CfgTimeout) begin
        timeout_r <= cfg_wdata[mrrd_pkg::TmoW-1:0];
      end
      if (cfg_we && cfg_idx == mrrd_pkg::CfgGap) begin
        gap_r <= cfg_wdata[mrrd_pkg::GapW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_out     = out_data_r.byte_out;
  assign out_ch.byte_valid   = out_data_r.byte_valid;
  assign out_ch.frame_end    = out_data_r.frame_end;
  assign out_ch.end_cause    = out_data_r.end_cause;
  assign out_ch.frame_length = out_data_r.frame_length;

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result register is full");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid_r)
    else $error("result not registered");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && !res.valid |=> !out_valid_r)
    else $error("transfer not retired");

endmodule

// ===== sim/modbus_rtu_response_delimiter_unit_test.sv =====
`timescale 1ns / 1ps

module modbus_rtu_response_delimiter_unit_test;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam mrrd_pkg::result_t NoResult = '0;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        rxb;
    bit                typed;
    bit                yields;
    mrrd_pkg::result_t res;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mrrd_pkg::CfgIdxW-1:0] cfg_idx;
  logic [mrrd_pkg::CfgDataW-1:0] cfg_wdata;

  mrrd_in_if  in_ch();
  mrrd_out_if out_ch();

  modbus_rtu_response_delimiter_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // delimiter state as seen at the accept edge
  logic [mrrd_pkg::TmoW-1:0] tmo_ticks = mrrd_pkg::TimeoutReset;
  logic [mrrd_pkg::GapW-1:0] gap_ticks = mrrd_pkg::GapReset;
  bit              armed = 1'b0;
  int unsigned     rx_count = 0;
  logic [7:0]      func_code = '0;
  logic [7:0]      byte_count = '0;
  int unsigned     resp_ticks = 0;
  int unsigned     quiet_ticks = 0;

  mrrd_pkg::result_t awaited_q [$];
  int unsigned fail_count = 0;
  int unsigned live_items = 0;
  bit          no_idle = 1'b0;

  probe_t probes [27] = '{
    '{mrrd_pkg::KindByte,  8'hFF, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'h00, 1'b1, 1'b0, NoResult},
    '{KindUnused,          8'h5A, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindStart, 8'h00, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h00, 1'b1, 1'b1,
      '{8'h00, 1'b1, 1'b0, mrrd_pkg::CauseLength, 10'd1}},
    '{mrrd_pkg::KindByte,  8'h83, 1'b1, 1'b1,
      '{8'h83, 1'b1, 1'b0, mrrd_pkg::CauseLength, 10'd2}},
    '{KindUnused,          8'h00, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'hFF, 1'b1, 1'b1,
      '{8'hFF, 1'b1, 1'b0, mrrd_pkg::CauseLength, 10'd3}},
    '{mrrd_pkg::KindByte,  8'h00, 1'b1, 1'b1,
      '{8'h00, 1'b1, 1'b0, mrrd_pkg::CauseLength, 10'd4}},
    '{mrrd_pkg::KindByte,  8'hFF, 1'b1, 1'b1,
      '{8'hFF, 1'b1, 1'b1, mrrd_pkg::CauseLength, 10'd5}},
    '{mrrd_pkg::KindByte,  8'h12, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindStart, 8'hFF, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h7F, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h01, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'h00, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'hFF, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'h00, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'h00, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindTick,  8'h00, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, mrrd_pkg::CauseSilence, 10'd2}},
    '{mrrd_pkg::KindStart, 8'h00, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h01, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindStart, 8'h00, 1'b1, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h01, 1'b1, 1'b1,
      '{8'h01, 1'b1, 1'b0, mrrd_pkg::CauseLength, 10'd1}},
    '{mrrd_pkg::KindByte,  8'h04, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h00, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'hAA, 1'b0, 1'b0, NoResult},
    '{mrrd_pkg::KindByte,  8'h55, 1'b1, 1'b1,
      '{8'h55, 1'b1, 1'b1, mrrd_pkg::CauseLength, 10'd5}}
  };

  function automatic int unsigned length_due();
    if (rx_count < 2) return 0;
    if (func_code[7]) return mrrd_pkg::ExcLength;
    if (func_code == mrrd_pkg::FcWriteMulti) return mrrd_pkg::WrMulLength;
    if ((func_code == mrrd_pkg::FcReadHold || func_code == mrrd_pkg::FcReadInput) &&
        rx_count >= 3)
      return byte_count + mrrd_pkg::RdHdrLength;
    return 0;
  endfunction

  function automatic bit delimit_step(input logic [1:0] k, input logic [7:0] b,
                                      output mrrd_pkg::result_t res);
    int unsigned due;
    int unsigned limit;
    int unsigned gap;
    bit          done;
    res = NoResult;
    if (k == mrrd_pkg::KindStart) begin
      armed = 1'b1;
      rx_count = 0;
      func_code = '0;
      byte_count = '0;
      resp_ticks = 0;
      quiet_ticks = 0;
      return 1'b0;
    end
    if (k == KindUnused || !armed) return 1'b0;
    if (k == mrrd_pkg::KindByte) begin
      if (rx_count == 1) func_code = b;
      else if (rx_count == 2) byte_count = b;
      rx_count++;
      quiet_ticks = 0;
      due = length_due();
      res.byte_out = b;
      res.byte_valid = 1'b1;
      res.frame_length = rx_count[mrrd_pkg::LenW-1:0];
      if (due != 0 && rx_count >= due) begin
        armed = 1'b0;
        res.frame_end = 1'b1;
        res.end_cause = mrrd_pkg::CauseLength;
      end else if (rx_count >= mrrd_pkg::MaxFrame) begin
        armed = 1'b0;
        res.frame_end = 1'b1;
        res.end_cause = mrrd_pkg::CauseOverflow;
      end
      return 1'b1;
    end
    limit = (tmo_ticks == 0) ? 1 : tmo_ticks;
    gap = (gap_ticks < mrrd_pkg::GapMin) ? mrrd_pkg::GapMin :
          (gap_ticks > mrrd_pkg::GapMax) ? mrrd_pkg::GapMax : gap_ticks;
    if (resp_ticks < 16'hFFFF) resp_ticks++;
    done = (resp_ticks >= limit);
    if (rx_count > 0 && length_due() == 0) begin
      if (quiet_ticks < 7'h7F) quiet_ticks++;
      if (quiet_ticks >= gap) done = 1'b1;
    end
    if (!done) return 1'b0;
    armed = 1'b0;
    res.frame_end = 1'b1;
    res.end_cause = (rx_count == 0) ? mrrd_pkg::CauseNoResp : mrrd_pkg::CauseSilence;
    res.frame_length = rx_count[mrrd_pkg::LenW-1:0];
    return 1'b1;
  endfunction

  // enter and leave at a falling edge; valid stays up for a back-to-back transfer
  task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                           output bit yields, output mrrd_pkg::result_t res);
    int unsigned hold;
    hold = no_idle ? 0 : $urandom_range(0, 18);
    if (hold != 0) begin
      in_ch.valid = 1'b0;
      repeat (hold) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = k;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (k == mrrd_pkg::KindStart || (armed && k != KindUnused)) live_items++;
    yields = delimit_step(k, b, res);
    @(negedge clk);
  endtask

  task automatic feed(input logic [1:0] k, input logic [7:0] b);
    bit                yields;
    mrrd_pkg::result_t res;
    send_item(k, b, yields, res);
    if (yields) awaited_q.push_back(res);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (awaited_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mrrd_pkg::CfgIdxW-1:0] idx,
                           input logic [mrrd_pkg::CfgDataW-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mrrd_pkg::CfgTimeout) tmo_ticks = data;
    else gap_ticks = data[mrrd_pkg::GapW-1:0];
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5)) feed(2'($urandom), 8'($urandom));
  endtask

  task automatic send_overflow();
    no_idle = 1'b1;
    feed(mrrd_pkg::KindStart, 8'h00);
    feed(mrrd_pkg::KindByte, 8'($urandom));
    feed(mrrd_pkg::KindByte, 8'h41);
    repeat (mrrd_pkg::MaxFrame + 6) feed(mrrd_pkg::KindByte, 8'($urandom));
  endtask

  task automatic send_response();
    logic [7:0]  resp_q [$];
    logic [7:0]  fc;
    int unsigned pick;
    int unsigned cnt;
    int unsigned trail;
    no_idle = ($urandom_range(0, 5) == 0);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: fc = mrrd_pkg::FcReadHold;
      2: fc = mrrd_pkg::FcReadInput;
      3, 4: fc = mrrd_pkg::FcWriteMulti;
      5, 6: fc = 8'h80 | 8'($urandom);
      default: fc = 8'($urandom);
    endcase
    resp_q.push_back(8'($urandom));
    resp_q.push_back(fc);
    if (fc == mrrd_pkg::FcReadHold || fc == mrrd_pkg::FcReadInput) begin
      cnt = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
      resp_q.push_back(8'(cnt));
      cnt += 2;
    end else if (fc[7]) begin
      cnt = 3;
    end else if (fc == mrrd_pkg::FcWriteMulti) begin
      cnt = 6;
    end else begin
      cnt = $urandom_range(0, 12);
    end
    repeat (cnt) resp_q.push_back(8'($urandom));
    // cut short, down to no response at all, or run past the end
    if ($urandom_range(0, 5) == 0) begin
      trail = $urandom_range(0, resp_q.size());
      while (resp_q.size() > trail) void'(resp_q.pop_back());
    end else if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) resp_q.push_back(8'($urandom));
    end
    feed(mrrd_pkg::KindStart, 8'($urandom));
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(0, 12)) feed(mrrd_pkg::KindTick, 8'($urandom));
    foreach (resp_q[i]) begin
      feed(mrrd_pkg::KindByte, resp_q[i]);
      pick = $urandom_range(0, 19);
      if (pick >= 14)
        repeat ((pick == 19) ? $urandom_range(1, 105) : $urandom_range(1, 3))
          feed(mrrd_pkg::KindTick, 8'($urandom));
    end
    trail = 0;
    while (armed && trail < 110) begin
      feed(mrrd_pkg::KindTick, 8'($urandom));
      trail++;
    end
  endtask

  initial begin : sink_side
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    mrrd_pkg::result_t got;
    mrrd_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.byte_out = out_ch.byte_out;
      got.byte_valid = out_ch.byte_valid;
      got.frame_end = out_ch.frame_end;
      got.end_cause = mrrd_pkg::cause_t'(out_ch.end_cause);
      got.frame_length = out_ch.frame_length;
      if (awaited_q.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        fail_count++;
      end else begin
        want = awaited_q.pop_front();
        if (got.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
          fail_count++;
        end
        if (got.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
          fail_count++;
        end
        if (got.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
          fail_count++;
        end
        if (got.end_cause !== want.end_cause) begin
          $error("end_cause: expected %0d, got %0d", want.end_cause, got.end_cause);
          fail_count++;
        end
        if (got.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [mrrd_pkg::CfgDataW-1:0] tmo_plan [7];
    logic [mrrd_pkg::CfgDataW-1:0] gap_plan [7];
    bit                yields;
    mrrd_pkg::result_t res;
    int unsigned       goal;
    tmo_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd10, 16'd40, 16'd300, 16'd1000};
    gap_plan = '{16'd0, 16'd127, 16'd100, 16'hFF8A, 16'd4, 16'd101, 16'd5};
    goal = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = mrrd_pkg::KindStart;
    in_ch.rx_byte = '0;
    cfg_we = 1'b0;
    cfg_idx = mrrd_pkg::CfgTimeout;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (probes[i]) begin
      send_item(probes[i].kind, probes[i].rxb, yields, res);
      if (probes[i].typed) begin
        yields = probes[i].yields;
        res = probes[i].res;
      end
      if (yields) awaited_q.push_back(res);
    end

    for (int p = 0; p <= 8; p++) begin
      if (p > 0) begin
        settle();
        if (p <= 7) begin
          write_reg(mrrd_pkg::CfgTimeout, tmo_plan[p-1]);
          write_reg(mrrd_pkg::CfgGap, gap_plan[p-1]);
        end else begin
          write_reg(mrrd_pkg::CfgTimeout, 16'($urandom_range(1, 200)));
          write_reg(mrrd_pkg::CfgGap, 16'($urandom_range(0, 127)));
        end
      end
      if (p == 3) send_overflow();
      goal += 170;
      while (live_items < goal) begin
        if ($urandom_range(0, 29) == 0) settle();
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_response();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
